@@ sv/ipv6tp_pkg.sv @@
// Shared types, constants and character decoding for the IPv6 text parser.
// No dependencies; every other file refers to this package by scoped names.
package ipv6tp_pkg;

  localparam int unsigned GROUPS     = 8;
  localparam int unsigned GROUP_W    = 16;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned NIBBLE_W   = 4;

  localparam logic [CHAR_W-1:0] COLON_CHAR = 8'h3A;

  // colon count limits
  localparam logic [CNT_W-1:0] MAX_COLONS      = 4'd8;
  localparam logic [CNT_W-1:0] MIN_COLONS_FULL = 4'd7;
  localparam logic [CNT_W-1:0] MIN_COLONS_DC   = 4'd2;

  typedef enum logic [1:0] {
    CH_HEX   = 2'd0,
    CH_COLON = 2'd1,
    CH_TERM  = 2'd2
  } char_class_t;

  // what the previous character of the string was
  typedef enum logic [3:0] {
    KIND_START  = 4'b0001,
    KIND_DIGIT  = 4'b0010,
    KIND_COLON1 = 4'b0100,
    KIND_COLON2 = 4'b1000
  } kind_t;

  typedef logic [GROUPS-1:0][GROUP_W-1:0] group_vec_t;

  // snapshot of one string at its terminating word
  typedef struct packed {
    logic             term;
    logic             ok;
    logic [CNT_W-1:0] l_cnt;
    logic [CNT_W-1:0] r_cnt;
    group_vec_t       left_grp;
    group_vec_t       right_grp;
  } scan_res_t;

  function automatic char_class_t char_class(input logic [CHAR_W-1:0] c);
    char_class_t cls;
    if (c == COLON_CHAR) begin
      cls = CH_COLON;
    end else if (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]}) begin
      cls = CH_HEX;
    end else begin
      cls = CH_TERM;
    end
    return cls;
  endfunction

endpackage

@@ sv/ipv6tp_if.sv @@
// Valid/ready channel interfaces for the IPv6 text parser.
// Depends on ipv6tp_pkg for field widths.
interface ipv6tp_in_if;
  logic                            valid;
  logic                            ready;
  logic [ipv6tp_pkg::CHAR_W-1:0]   char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface ipv6tp_out_if;
  logic        valid;
  logic        ready;
  logic        parse_ok;
  logic [63:0] address_high;
  logic [63:0] address_low;

  modport source (output valid, output parse_ok, output address_high, output address_low,
                  input ready);
  modport sink   (input valid, input parse_ok, input address_high, input address_low,
                  output ready);
endinterface

@@ sv/ipv6tp_scan.sv @@
// Per-character string state: colon rules, digit accumulation, group storage.
// Depends on ipv6tp_pkg.
module ipv6tp_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          char_fire,
  input  logic [ipv6tp_pkg::CHAR_W-1:0] char_code,
  output ipv6tp_pkg::scan_res_t         res
);

  logic [ipv6tp_pkg::GROUP_W-1:0] acc_r, acc_nxt;
  logic [ipv6tp_pkg::CNT_W-1:0]   ct_r, ct_nxt;
  logic [ipv6tp_pkg::CNT_W-1:0]   l_cnt_r, l_cnt_nxt;
  logic [ipv6tp_pkg::CNT_W-1:0]   r_cnt_r, r_cnt_nxt;
  logic                           dcs_r, dcs_nxt;
  logic                           fail_r, fail_nxt;
  ipv6tp_pkg::kind_t              prev_r, prev_nxt;
  ipv6tp_pkg::group_vec_t         left_r, left_nxt;
  ipv6tp_pkg::group_vec_t         right_r, right_nxt;

  logic [ipv6tp_pkg::GROUP_W-1:0]  acc;
  logic [ipv6tp_pkg::CNT_W-1:0]    ct, lc, rc;
  logic                            dcs, fail, fin, term;
  ipv6tp_pkg::kind_t               prev;
  ipv6tp_pkg::group_vec_t          lgrp, rgrp;
  ipv6tp_pkg::char_class_t         cls;
  logic [ipv6tp_pkg::NIBBLE_W-1:0] hv;

  function automatic logic [ipv6tp_pkg::NIBBLE_W-1:0] hex_value(
    input logic [ipv6tp_pkg::CHAR_W-1:0] c
  );
    // letters carry bit 6; their low nibble is one for 'a' and 'A'
    return c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

  function automatic logic colon_over(
    input logic [ipv6tp_pkg::CNT_W-1:0] cnt,
    input logic                         dc,
    input logic [ipv6tp_pkg::CNT_W-1:0] l,
    input logic [ipv6tp_pkg::CNT_W-1:0] r
  );
    logic over;
    over = 1'b0;
    if (cnt > ipv6tp_pkg::MAX_COLONS) begin
      over = 1'b1;
    end else if (cnt == ipv6tp_pkg::MAX_COLONS &&
                 (!dc || (l != '0 && r != '0))) begin
      over = 1'b1;
    end
    return over;
  endfunction

  always_comb begin
    acc  = acc_r;
    ct   = ct_r;
    lc   = l_cnt_r;
    rc   = r_cnt_r;
    dcs  = dcs_r;
    fail = fail_r;
    prev = prev_r;
    lgrp = left_r;
    rgrp = right_r;
    fin  = 1'b0;
    term = 1'b0;
    cls  = ipv6tp_pkg::char_class(char_code);
    hv   = hex_value(char_code);

    if (char_fire) begin
      case (cls)
        ipv6tp_pkg::CH_COLON: begin
          if (!fail) begin
            case (prev)
              ipv6tp_pkg::KIND_COLON2: begin
                fail = 1'b1;
              end
              ipv6tp_pkg::KIND_COLON1: begin
                if (dcs) begin
                  fail = 1'b1;
                end else begin
                  dcs  = 1'b1;
                  ct   = ct + 4'd2;
                  fail = colon_over(ct, dcs, lc, rc);
                end
                prev = ipv6tp_pkg::KIND_COLON2;
              end
              default: begin
                fin  = (prev == ipv6tp_pkg::KIND_DIGIT);
                prev = ipv6tp_pkg::KIND_COLON1;
              end
            endcase
          end
        end
        ipv6tp_pkg::CH_HEX: begin
          if (!fail) begin
            // a single colon before a digit: reject a leading one, count the rest
            if (prev == ipv6tp_pkg::KIND_COLON1) begin
              if (ct == '0 && lc == '0 && !dcs) begin
                fail = 1'b1;
              end else begin
                ct   = ct + 4'd1;
                fail = colon_over(ct, dcs, lc, rc);
              end
            end
            if (!fail) begin
              if (prev == ipv6tp_pkg::KIND_DIGIT) begin
                acc = {acc[11:0], hv};
              end else begin
                if (dcs && prev != ipv6tp_pkg::KIND_START) begin
                  rc = rc + 4'd1;
                end
                acc = {12'd0, hv};
              end
              prev = ipv6tp_pkg::KIND_DIGIT;
            end
          end
        end
        default: begin
          term = 1'b1;
          if (!fail) begin
            if (prev == ipv6tp_pkg::KIND_DIGIT) begin
              fin = 1'b1;
            end else if (prev == ipv6tp_pkg::KIND_COLON1) begin
              fail = 1'b1;
            end
          end
          if (!fail) begin
            fail = dcs ? (ct < ipv6tp_pkg::MIN_COLONS_DC) : (ct < ipv6tp_pkg::MIN_COLONS_FULL);
          end
        end
      endcase

      // close the group: left of '::' by index, right of it into a shift line
      if (fin) begin
        if (dcs) begin
          rgrp = {acc, rgrp[ipv6tp_pkg::GROUPS-1:1]};
        end else begin
          if (lc < 4'(ipv6tp_pkg::GROUPS)) begin
            lgrp[lc[2:0]] = acc;
          end
          lc = lc + 4'd1;
        end
      end
    end

    res.term      = term;
    res.ok        = !fail;
    res.l_cnt     = lc;
    res.r_cnt     = rc;
    res.left_grp  = lgrp;
    res.right_grp = rgrp;

    left_nxt  = lgrp;
    right_nxt = rgrp;
    if (term) begin
      acc_nxt   = '0;
      ct_nxt    = '0;
      l_cnt_nxt = '0;
      r_cnt_nxt = '0;
      dcs_nxt   = 1'b0;
      fail_nxt  = 1'b0;
      prev_nxt  = ipv6tp_pkg::KIND_START;
    end else begin
      acc_nxt   = acc;
      ct_nxt    = ct;
      l_cnt_nxt = lc;
      r_cnt_nxt = rc;
      dcs_nxt   = dcs;
      fail_nxt  = fail;
      prev_nxt  = prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      ct_r    <= '0;
      l_cnt_r <= '0;
      r_cnt_r <= '0;
      dcs_r   <= 1'b0;
      fail_r  <= 1'b0;
      prev_r  <= ipv6tp_pkg::KIND_START;
    end else begin
      acc_r   <= acc_nxt;
      ct_r    <= ct_nxt;
      l_cnt_r <= l_cnt_nxt;
      r_cnt_r <= r_cnt_nxt;
      dcs_r   <= dcs_nxt;
      fail_r  <= fail_nxt;
      prev_r  <= prev_nxt;
    end
  end

  // group payload: only slots written in the current string are ever selected
  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
  end

endmodule

@@ sv/ipv6tp_pack.sv @@
// Builds the 128-bit address from left groups, right-aligned right groups and zero fill.
// Depends on ipv6tp_pkg.
module ipv6tp_pack (
  input  ipv6tp_pkg::scan_res_t res,
  output logic [63:0]           addr_high,
  output logic [63:0]           addr_low
);

  ipv6tp_pkg::group_vec_t lane;

  always_comb begin
    for (int i = 0; i < ipv6tp_pkg::GROUPS; i++) begin
      if (4'(i) < res.l_cnt) begin
        lane[i] = res.left_grp[i];
      end else if ((5'(i) + {1'b0, res.r_cnt}) >= 5'(ipv6tp_pkg::GROUPS)) begin
        lane[i] = res.right_grp[i];
      end else begin
        lane[i] = '0;
      end
    end
  end

  assign addr_high = {lane[0], lane[1], lane[2], lane[3]};
  assign addr_low  = {lane[4], lane[5], lane[6], lane[7]};

endmodule

@@ sv/ipv6_text_address_parser_top.sv @@
// Top level of the IPv6 text address parser: input stage, scanner, packer, result register.
// Depends on ipv6tp_pkg, ipv6tp_if, ipv6tp_scan and ipv6tp_pack.
//
// Usage:
//   in_ch carries one character word per handshake. Hex digits and ':' build the
//   address; any other byte ends the string and produces exactly one result word.
//   out_ch carries parse_ok and the address as two 64-bit halves, group 0 in the
//   top bits of address_high. A rejected string returns parse_ok = 0 together
//   with the last accepted address; an accepted one replaces that held address.
// Timing:
//   One character per cycle, sustained, while no terminator is held up by a stalled
//   result. A terminator is registered in the input stage, then scanned and packed
//   into the result register that drives out_ch. The path is one input register,
//   combinational scan and pack logic, one result register.
// Stall behavior:
//   While a result waits on out_ch, digits and colons keep flowing through the
//   scanner; only a new terminator holds in the input stage until the result
//   register frees up, and in_ch.ready drops once that stage is blocked.
// Reset:
//   rst_n (synchronous, active low) empties both stages, clears the per-string
//   state and zeroes the held address. No clearing pass is needed.
module ipv6_text_address_parser_top (
  input logic          clk,
  input logic          rst_n,
  ipv6tp_in_if.sink    in_ch,
  ipv6tp_out_if.source out_ch
);

  logic                          s1_valid_r, s1_valid_nxt;
  logic [ipv6tp_pkg::CHAR_W-1:0] s1_char_r;
  logic                          s1_term, s1_take, out_free, in_fire;

  logic                          out_valid_r, out_valid_nxt;
  logic                          ok_r;
  logic [63:0]                   out_hi_r, out_lo_r;
  logic [63:0]                   held_hi_r, held_lo_r;

  ipv6tp_pkg::scan_res_t         res;
  logic [63:0]                   pack_hi, pack_lo;

  // input stage: a terminator waits here if the result register is still full
  assign s1_term  = (ipv6tp_pkg::char_class(s1_char_r) == ipv6tp_pkg::CH_TERM);
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_take  = s1_valid_r && (!s1_term || out_free);
  assign in_ch.ready = !s1_valid_r || s1_take;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_ch.char_code;
    end
  end

  ipv6tp_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_fire (s1_take),
    .char_code (s1_char_r),
    .res       (res)
  );

  ipv6tp_pack u_pack (
    .res       (res),
    .addr_high (pack_hi),
    .addr_low  (pack_lo)
  );

  // result register: load on a terminator, drop once the receiver takes it
  always_comb begin
    if (res.term) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      held_hi_r   <= '0;
      held_lo_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (res.term && res.ok) begin
        held_hi_r <= pack_hi;
        held_lo_r <= pack_lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.term) begin
      ok_r     <= res.ok;
      out_hi_r <= res.ok ? pack_hi : held_hi_r;
      out_lo_r <= res.ok ? pack_lo : held_lo_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.parse_ok     = ok_r;
  assign out_ch.address_high = out_hi_r;
  assign out_ch.address_low  = out_lo_r;

`ifndef SYNTH
  // a waiting terminator must not pass into a full, stalled result register
  a_term_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_term && out_valid_r && !out_ch.ready) |=> s1_valid_r)
    else $error("terminator left the input stage while the result was stalled");

  // a rejected string reports the address held before it
  a_reject_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res.term && !res.ok) |=>
      (out_ch.address_high == $past(held_hi_r) && out_ch.address_low == $past(held_lo_r)))
    else $error("rejected string did not report the held address");

  // an accepted string becomes the held address
  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res.term && res.ok) |=>
      (held_hi_r == out_ch.address_high && held_lo_r == out_ch.address_low && out_ch.parse_ok))
    else $error("accepted address not stored");
`endif

endmodule
